// File: rtl/core/m4v4_pkg.sv
// m4v4_pkg: shared widths, payload types, pipeline control struct and the
// reset image of the matrix registers for the 4x4 matrix-vector transform.
// No dependencies.
package m4v4_pkg;

  localparam int VEC_W     = 16;
  localparam int OUT_W     = 22;
  localparam int LANES     = 4;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 32;
  localparam int PROD_W    = 2 * VEC_W;
  localparam int SUM_W     = PROD_W + 2;

  typedef logic signed [VEC_W-1:0] elem_t;
  typedef logic signed [OUT_W-1:0] res_t;
  typedef logic [CFG_W-1:0]        cfg_word_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } pipe_ctrl_t;

  localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
    32'h0000_1000, 32'h0000_0000,
    32'h1000_0000, 32'h0000_0000,
    32'h0000_0000, 32'h0000_1000,
    32'h0000_0000, 32'h1000_0000
  };

endpackage

// File: rtl/core/m4v4_lane.sv
// m4v4_lane: one matrix row dot the input vector; registered products,
// then sum and floor shift to the output format.
// Depends on m4v4_pkg.
module m4v4_lane #(
  parameter int FRAC_BITS = 12,
  parameter int COLS      = 4,
  parameter bit ROW_EN    = 1'b1
) (
  input  logic           clk,
  input  logic           en,
  input  m4v4_pkg::elem_t row [m4v4_pkg::LANES],
  input  m4v4_pkg::elem_t vec [m4v4_pkg::LANES],
  output m4v4_pkg::res_t  dot
);

  logic signed [m4v4_pkg::PROD_W-1:0] prod_r [m4v4_pkg::LANES];
  logic signed [m4v4_pkg::SUM_W-1:0]  sum;
  logic signed [m4v4_pkg::SUM_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < m4v4_pkg::LANES; c++) begin
        if (c < COLS) begin
          prod_r[c] <= row[c] * vec[c];
        end else begin
          prod_r[c] <= '0;
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int c = 0; c < m4v4_pkg::LANES; c++) begin
      sum = sum + m4v4_pkg::SUM_W'(prod_r[c]);
    end
    shifted = sum >>> FRAC_BITS;
    dot     = ROW_EN ? shifted[m4v4_pkg::OUT_W-1:0] : '0;
  end

endmodule

// File: rtl/core/m4v4_merge.sv
// m4v4_merge: pipeline flow control and the output register that gathers
// the four lane results into one result transfer.
// Depends on m4v4_pkg.
module m4v4_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output m4v4_pkg::pipe_ctrl_t ctrl,
  input  m4v4_pkg::res_t       lane_dot [m4v4_pkg::LANES],
  output logic                 out_valid,
  input  logic                 out_ready,
  output m4v4_pkg::res_t       res [m4v4_pkg::LANES]
);

  logic           v1_r;
  logic           out_valid_r;
  m4v4_pkg::res_t res_r [m4v4_pkg::LANES];

  assign ctrl.s2_en = !out_valid_r || out_ready;
  assign ctrl.s1_en = !v1_r || ctrl.s2_en;
  assign in_ready   = ctrl.s1_en;
  assign out_valid  = out_valid_r;
  assign res        = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.s1_en) begin
        v1_r <= in_valid;
      end
      if (ctrl.s2_en) begin
        out_valid_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s2_en) begin
      res_r <= lane_dot;
    end
  end

endmodule

// File: rtl/core/mat4_vec4_transform_top.sv
// mat4_vec4_transform_top: top level of the 4x4 matrix by vector transform.
// Holds the matrix registers; instantiates m4v4_lane (x4) and m4v4_merge.
// Depends on m4v4_pkg.
//
// Each input vector (Q4.12) is multiplied by the 4x4 matrix held in eight
// 32-bit registers (two Q4.12 elements each, lower column in bits 15:0);
// every output component is the row dot product shifted right by FRAC_BITS
// with floor rounding, in Q10.12. One vector is taken per clock while
// in_ready is high; a result is computed by four row lanes running
// in parallel (product register, then adder tree into the output register).
// Input ready drops only while the output register is full and stalled.
// Writes to cfg are always taken; indexes above seven are ignored. Reset
// loads the identity matrix.
module mat4_vec4_transform_top #(
  parameter int FRAC_BITS = 12,
  parameter int DIM       = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [m4v4_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [m4v4_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [m4v4_pkg::VEC_W-1:0]    in_vec_x,
  input  logic signed [m4v4_pkg::VEC_W-1:0]    in_vec_y,
  input  logic signed [m4v4_pkg::VEC_W-1:0]    in_vec_z,
  input  logic signed [m4v4_pkg::VEC_W-1:0]    in_vec_w,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [m4v4_pkg::OUT_W-1:0]    out_0,
  output logic signed [m4v4_pkg::OUT_W-1:0]    out_1,
  output logic signed [m4v4_pkg::OUT_W-1:0]    out_2,
  output logic signed [m4v4_pkg::OUT_W-1:0]    out_3
);

  m4v4_pkg::cfg_word_t  cfg_r [m4v4_pkg::NUM_REGS];
  m4v4_pkg::elem_t      vec [m4v4_pkg::LANES];
  m4v4_pkg::elem_t      mat [m4v4_pkg::LANES][m4v4_pkg::LANES];
  m4v4_pkg::res_t       lane_dot [m4v4_pkg::LANES];
  m4v4_pkg::res_t       res [m4v4_pkg::LANES];
  m4v4_pkg::pipe_ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= m4v4_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_idx < m4v4_pkg::CFG_IDX_W'(m4v4_pkg::NUM_REGS))) begin
      cfg_r[cfg_idx[m4v4_pkg::REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign vec[0] = in_vec_x;
  assign vec[1] = in_vec_y;
  assign vec[2] = in_vec_z;
  assign vec[3] = in_vec_w;

  for (genvar r = 0; r < m4v4_pkg::LANES; r++) begin : g_row
    for (genvar c = 0; c < m4v4_pkg::LANES; c++) begin : g_col
      assign mat[r][c] = cfg_r[2 * r + c / 2][(c % 2) * m4v4_pkg::VEC_W +: m4v4_pkg::VEC_W];
    end

    m4v4_lane #(
      .FRAC_BITS (FRAC_BITS),
      .COLS      (DIM),
      .ROW_EN    (r < DIM)
    ) u_lane (
      .clk (clk),
      .en  (ctrl.s1_en),
      .row (mat[r]),
      .vec (vec),
      .dot (lane_dot[r])
    );
  end

  m4v4_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ctrl      (ctrl),
    .lane_dot  (lane_dot),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_0 = res[0];
  assign out_1 = res[1];
  assign out_2 = res[2];
  assign out_3 = res[3];

endmodule

// File: rtl/core/m4v4_checker.sv
// m4v4_checker: port-level assertions for mat4_vec4_transform_top, and the
// bind that attaches them. Depends on m4v4_pkg.
module m4v4_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [m4v4_pkg::OUT_W-1:0] out_0,
  input logic signed [m4v4_pkg::OUT_W-1:0] out_1,
  input logic signed [m4v4_pkg::OUT_W-1:0] out_2,
  input logic signed [m4v4_pkg::OUT_W-1:0] out_3
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_0) && $stable(out_1) &&
      $stable(out_2) && $stable(out_3))
    else $error("result changed while stalled");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an input transfer two cycles before");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output side is free");

endmodule

bind mat4_vec4_transform_top m4v4_checker u_m4v4_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_0     (out_0),
  .out_1     (out_1),
  .out_2     (out_2),
  .out_3     (out_3)
);
